@@ rtl/core/tmv_pkg.sv @@
// Shared constants, codes and control types for the triangular matrix-vector multiplier.
`default_nettype none
package tmv_pkg;

   localparam int MAX_SIZE   = 64;
   localparam int IDX_W      = $clog2(MAX_SIZE);
   localparam int MAT_ADDR_W = 2 * IDX_W;
   localparam int MAT_DEPTH  = MAX_SIZE * MAX_SIZE;
   localparam int SIZE_W     = 7;
   localparam int MAT_W      = 32;
   localparam int VEC_W      = 48;
   localparam int FRAC_W     = 24;
   localparam int MUL_B_W    = VEC_W - FRAC_W + 1;
   localparam int PROD_W     = MAT_W + MUL_B_W;
   localparam int ACC_W      = 64;
   localparam int CSR_IDX_W  = 2;

   // 1.0 in Q8.24, used in place of the diagonal for unit-diagonal runs
   localparam logic signed [MAT_W-1:0] ONE_Q = MAT_W'(1) << FRAC_W;

   localparam logic [1:0] CMD_MATRIX = 2'd0;
   localparam logic [1:0] CMD_VECTOR = 2'd1;
   localparam logic [1:0] CMD_START  = 2'd2;

   localparam logic [1:0] MODE_UPPER   = 2'd0;
   localparam logic [1:0] MODE_LOWER   = 2'd1;
   localparam logic [1:0] MODE_LOWER_T = 2'd2;
   localparam logic [1:0] MODE_UPPER_T = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_DIAG   = 2'd2;

   typedef struct packed {
      logic clear;
      logic mul_en;
      logic mul_lo;
      logic unit_sub;
   } mac_ctrl_type;

   typedef struct packed {
      logic                  en;
      logic [MAT_ADDR_W-1:0] mat_addr;
      logic [IDX_W-1:0]      vec_addr;
   } rd_req_type;

   typedef struct packed {
      logic             busy;
      logic             out_load;
      logic             out_last;
      logic [IDX_W-1:0] out_index;
   } seq_status_type;

endpackage
`default_nettype wire

@@ rtl/core/tmv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/tmv_mac.sv @@
// Shared multiply-accumulate unit: one 32x25 multiplier, product register, wide accumulator.
`default_nettype none
module tmv_mac
   import tmv_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire mac_ctrl_type             ctrl,
   input  wire logic signed [MAT_W-1:0]  mat_data,
   input  wire logic signed [VEC_W-1:0]  vec_data,
   output logic signed      [VEC_W-1:0]  sat_value
);

   logic signed [MAT_W-1:0]   a_op;
   logic signed [MUL_B_W-1:0] b_op;
   logic signed [PROD_W-1:0]  prod;
   logic signed [PROD_W-1:0]  prod_ff;
   logic                      prod_vld_ff, prod_vld_in;
   logic                      prod_lo_ff;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [ACC_W-1:0]   addend;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-VEC_W:0]      top_bits;

   // x = xh*2^24 + xl with xh signed and xl in [0, 2^24); the low partial
   // product is floored by an arithmetic shift when it is added
   always_comb begin
      a_op = ctrl.unit_sub ? ONE_Q : mat_data;
      if (ctrl.mul_lo) begin
         b_op = {1'b0, vec_data[FRAC_W-1:0]};
      end else begin
         b_op = {vec_data[VEC_W-1], vec_data[VEC_W-1:FRAC_W]};
      end
      prod = a_op * b_op;
   end

   assign prod_vld_in = ctrl.mul_en;
   assign prod_ext    = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign addend      = prod_lo_ff ? (prod_ext >>> FRAC_W) : prod_ext;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + addend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
      if (ctrl.mul_en) begin
         prod_ff    <= prod;
         prod_lo_ff <= ctrl.mul_lo;
      end
      acc_ff <= acc_in;
   end

   // clamp to 48 bits when the bits above the sign disagree
   assign top_bits = acc_ff[ACC_W-1:VEC_W-1];

   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         sat_value = acc_ff[VEC_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sat_value = {1'b1, {(VEC_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(VEC_W-1){1'b1}}};
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/tmv_seq.sv @@
// Sequencer: walks rows and the used columns of the triangle, drives reads and the shared MAC.
`default_nettype none
module tmv_seq
   import tmv_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SIZE_W-1:0] vector_size,
   input  wire logic [1:0]        mode,
   input  wire logic              unit_diag,
   input  wire logic              out_free,
   output mac_ctrl_type           ctrl,
   output rd_req_type             rd,
   output seq_status_type         status
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ISSUE = 3'd1;
   localparam logic [2:0] S_LO    = 3'd2;
   localparam logic [2:0] S_HI    = 3'd3;
   localparam logic [2:0] S_ADD   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic [SIZE_W-1:0] size_eff;
   logic             k_ge_i;
   logic             transposed;
   logic             unit;
   logic [IDX_W-1:0] k_end;
   logic [IDX_W-1:0] rd_k;
   logic             diag_sub;

   always_comb begin
      k_ge_i     = (mode == MODE_UPPER) || (mode == MODE_LOWER_T);
      transposed = (mode == MODE_LOWER_T) || (mode == MODE_UPPER_T);
      unit       = unit_diag && ((mode == MODE_LOWER) || (mode == MODE_LOWER_T));
      size_eff   = (vector_size > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : vector_size;
      k_end      = k_ge_i ? last_ff : i_ff;
      diag_sub   = unit && (k_ff == i_ff);
      // during HI the next column's read goes out
      rd_k       = (state_ff == S_HI) ? (k_ff + IDX_W'(1)) : k_ff;
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      last_in  = last_ff;
      ctrl     = '0;
      rd.en    = 1'b0;
      rd.mat_addr = transposed ? {rd_k, i_ff} : {i_ff, rd_k};
      rd.vec_addr = rd_k;
      status.out_load  = 1'b0;
      status.out_last  = (i_ff == last_ff);
      status.out_index = i_ff;
      status.busy      = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (start && (size_eff != '0)) begin
               last_in  = IDX_W'(size_eff - SIZE_W'(1));
               i_in     = '0;
               k_in     = '0;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            rd.en      = 1'b1;
            ctrl.clear = 1'b1;
            state_in   = S_LO;
         end
         S_LO: begin
            ctrl.mul_en   = 1'b1;
            ctrl.mul_lo   = 1'b1;
            ctrl.unit_sub = diag_sub;
            state_in      = S_HI;
         end
         S_HI: begin
            ctrl.mul_en   = 1'b1;
            ctrl.unit_sub = diag_sub;
            if (k_ff == k_end) begin
               state_in = S_ADD;
            end else begin
               rd.en    = 1'b1;
               k_in     = k_ff + IDX_W'(1);
               state_in = S_LO;
            end
         end
         S_ADD: begin
            // last high product lands in the accumulator
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               status.out_load = 1'b1;
               if (i_ff == last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  k_in     = k_ge_i ? (i_ff + IDX_W'(1)) : '0;
                  state_in = S_ISSUE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff    <= i_in;
      k_ff    <= k_in;
      last_ff <= last_in;
   end

endmodule
`default_nettype wire

@@ rtl/core/triangular_matrix_vector_multiply_top.sv @@
// Top level: load/start request port, config registers, matrix and vector RAMs, result register.
// Loads (matrix or vector writes) are accepted back to back while no run is in progress.
// A start runs row by row: each row goes through ISSUE, then LO and HI for each used term of
// that row, as the one shared multiplier forms two partial products per term, then ADD and OUT.
// OUT waits while the result register is held; no request is taken while a run is in progress.
// Reset: synchronous; config returns to size 64, mode 0, unit_diag 0; RAMs keep contents.
`default_nettype none
module triangular_matrix_vector_multiply_top
   import tmv_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_cmd,
   input  wire logic [IDX_W-1:0]        req_row,
   input  wire logic [IDX_W-1:0]        req_col,
   input  wire logic signed [MAT_W-1:0] req_matrix_value,
   input  wire logic signed [VEC_W-1:0] req_vector_value,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [IDX_W-1:0]             rsp_index,
   output logic signed [VEC_W-1:0]      rsp_result_value,
   output logic                         rsp_last,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [SIZE_W-1:0]       csr_wdata
);

   logic [SIZE_W-1:0]        vector_size_ff, vector_size_in;
   logic [1:0]               mode_ff, mode_in;
   logic                     unit_diag_ff, unit_diag_in;
   logic                     req_fire;
   logic                     start;
   logic                     mat_wr;
   logic                     vec_wr;
   logic                     out_free;
   mac_ctrl_type             ctrl;
   rd_req_type               rd;
   seq_status_type           status;
   logic [MAT_W-1:0]         mat_rd_data;
   logic [VEC_W-1:0]         vec_rd_data;
   logic signed [VEC_W-1:0]  sat_value;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]         rsp_index_ff;
   logic signed [VEC_W-1:0]  rsp_value_ff;
   logic                     rsp_last_ff;

   assign req_ready = !status.busy;
   assign req_fire  = req_valid && req_ready;
   assign start     = req_fire && (req_cmd == CMD_START);
   assign mat_wr    = req_fire && (req_cmd == CMD_MATRIX);
   assign vec_wr    = req_fire && (req_cmd == CMD_VECTOR);

   always_comb begin
      vector_size_in = vector_size_ff;
      mode_in        = mode_ff;
      unit_diag_in   = unit_diag_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_VECTOR_SIZE: vector_size_in = csr_wdata;
            CSR_MODE:        mode_in        = csr_wdata[1:0];
            CSR_UNIT_DIAG:   unit_diag_in   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_size_ff <= SIZE_W'(MAX_SIZE);
         mode_ff        <= MODE_UPPER;
         unit_diag_ff   <= 1'b0;
      end else begin
         vector_size_ff <= vector_size_in;
         mode_ff        <= mode_in;
         unit_diag_ff   <= unit_diag_in;
      end
   end

   tmv_ram #(
      .WIDTH (MAT_W),
      .DEPTH (MAT_DEPTH)
   ) u_mat_ram (
      .clock   (clock),
      .wr_en   (mat_wr),
      .wr_addr ({req_row, req_col}),
      .wr_data (req_matrix_value),
      .rd_en   (rd.en),
      .rd_addr (rd.mat_addr),
      .rd_data (mat_rd_data)
   );

   tmv_ram #(
      .WIDTH (VEC_W),
      .DEPTH (MAX_SIZE)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (vec_wr),
      .wr_addr (req_row),
      .wr_data (req_vector_value),
      .rd_en   (rd.en),
      .rd_addr (rd.vec_addr),
      .rd_data (vec_rd_data)
   );

   tmv_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .vector_size (vector_size_ff),
      .mode        (mode_ff),
      .unit_diag   (unit_diag_ff),
      .out_free    (out_free),
      .ctrl        (ctrl),
      .rd          (rd),
      .status      (status)
   );

   tmv_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .mat_data  ($signed(mat_rd_data)),
      .vec_data  ($signed(vec_rd_data)),
      .sat_value (sat_value)
   );

   // result register parts the sequencer from the response side
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (status.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (status.out_load) begin
         rsp_index_ff <= status.out_index;
         rsp_value_ff <= sat_value;
         rsp_last_ff  <= status.out_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_index        = rsp_index_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      status.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken result");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (status.out_load && status.out_last) |=> req_ready)
      else $error("sequencer not idle after final result");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && (vector_size_ff != '0)) |=> !req_ready)
      else $error("start with nonzero size did not begin a run");

endmodule
`default_nettype wire
